[rtl/ost_pkg.sv]
// Shared constants and register codes for the orbit steering datapath.
package ost_pkg;

  // Register file.
  localparam int REG_W   = 31;
  localparam int CIDX_W  = 2;
  localparam logic [CIDX_W-1:0] REG_ORBIT_SPEED    = 2'd0;
  localparam logic [CIDX_W-1:0] REG_TURN_CLOCKWISE = 2'd1;
  localparam logic [CIDX_W-1:0] REG_GOAL_WEIGHT    = 2'd2;
  localparam logic [REG_W-1:0]  SPEED_RESET        = 31'd65536;

  // Velocity word.
  localparam int VEL_W   = 32;
  localparam int VSUM_W  = VEL_W + 2;
  localparam int VMAG_W  = VEL_W + 1;

  // Unit vector normalization: largest component lands with its top bit here.
  localparam int NORM_TOP = 29;
  localparam int A_W      = NORM_TOP + 1;
  localparam int SUM_W    = 2 * A_W + 2;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int SREM_W   = ROOT_W + 3;

endpackage

[rtl/ost_unit.sv]
// Pipelined unit vector: normalize, square sum, square root, per-lane division.
module ost_unit #(
  parameter int N    = 2,
  parameter int MW   = 33,
  parameter int FRAC = 16,
  parameter int SW   = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [MW-1:0]       in_mag [N],
  input  logic [SW-1:0]       in_side,
  output logic                out_valid,
  output logic [FRAC:0]       out_u [N],
  output logic                out_zero,
  output logic [SW-1:0]       out_side
);
  import ost_pkg::*;

  localparam int PW       = $clog2(MW);
  localparam int UW       = FRAC + 1;
  localparam int DEN_W    = ROOT_W + FRAC + 1;
  localparam int SQ_STEPS = ROOT_W;
  localparam int DV_STEPS = UW;

  // Stage 1: largest magnitude.
  logic [MW-1:0] s1_max_nxt;
  logic [MW-1:0] s1_max_r;
  logic [MW-1:0] s1_mag_r [N];
  logic [SW-1:0] s1_side_r;
  logic          s1_valid_r;

  always_comb begin
    s1_max_nxt = '0;
    for (int i = 0; i < N; i++) begin
      if (in_mag[i] > s1_max_nxt) s1_max_nxt = in_mag[i];
    end
  end

  // Stage 2: position of the leading one.
  logic [PW-1:0] s2_p_nxt;
  logic [PW-1:0] s2_p_r;
  logic          s2_zero_r;
  logic [MW-1:0] s2_mag_r [N];
  logic [SW-1:0] s2_side_r;
  logic          s2_valid_r;

  always_comb begin
    s2_p_nxt = '0;
    for (int b = 0; b < MW; b++) begin
      if (s1_max_r[b]) s2_p_nxt = PW'(b);
    end
  end

  // Stage 3: common shift so the largest has its top bit at NORM_TOP.
  logic [A_W-1:0]    s3_a_nxt [N];
  logic [A_W-1:0]    s3_a_r [N];
  logic              s3_zero_r;
  logic [SW-1:0]     s3_side_r;
  logic              s3_valid_r;

  always_comb begin
    logic [MW+A_W-1:0] wide;
    for (int i = 0; i < N; i++) begin
      wide = {{A_W{1'b0}}, s2_mag_r[i]};
      if (32'(s2_p_r) > NORM_TOP) begin
        wide = wide >> (32'(s2_p_r) - NORM_TOP);
      end else begin
        wide = wide << (NORM_TOP - 32'(s2_p_r));
      end
      s3_a_nxt[i] = wide[A_W-1:0];
    end
  end

  // Stage 4: squares. Stage 5: sum of squares.
  logic [2*A_W-1:0] s4_sq_r [N];
  logic [A_W-1:0]   s4_a_r [N];
  logic             s4_zero_r;
  logic [SW-1:0]    s4_side_r;
  logic             s4_valid_r;

  logic [SUM_W-1:0] s5_sum_nxt;
  logic [SUM_W-1:0] s5_sum_r;
  logic [A_W-1:0]   s5_a_r [N];
  logic             s5_zero_r;
  logic [SW-1:0]    s5_side_r;
  logic             s5_valid_r;

  always_comb begin
    s5_sum_nxt = '0;
    for (int i = 0; i < N; i++) begin
      s5_sum_nxt = s5_sum_nxt + SUM_W'(s4_sq_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_max_r  <= s1_max_nxt;
      s1_side_r <= in_side;
      s2_p_r    <= s2_p_nxt;
      s2_zero_r <= (s1_max_r == '0);
      s2_side_r <= s1_side_r;
      s3_zero_r <= s2_zero_r;
      s3_side_r <= s2_side_r;
      s4_zero_r <= s3_zero_r;
      s4_side_r <= s3_side_r;
      s5_sum_r  <= s5_sum_nxt;
      s5_zero_r <= s4_zero_r;
      s5_side_r <= s4_side_r;
      for (int i = 0; i < N; i++) begin
        s1_mag_r[i] <= in_mag[i];
        s2_mag_r[i] <= s1_mag_r[i];
        s3_a_r[i]   <= s3_a_nxt[i];
        s4_sq_r[i]  <= s3_a_r[i] * s3_a_r[i];
        s4_a_r[i]   <= s3_a_r[i];
        s5_a_r[i]   <= s4_a_r[i];
      end
    end
  end

  // Square root, two radicand bits per stage.
  logic [SUM_W-1:0]  sq_rad_r  [SQ_STEPS+1];
  logic [SREM_W-1:0] sq_rem_r  [SQ_STEPS+1];
  logic [ROOT_W-1:0] sq_root_r [SQ_STEPS+1];
  logic [A_W-1:0]    sq_a_r    [SQ_STEPS+1][N];
  logic              sq_zero_r [SQ_STEPS+1];
  logic [SW-1:0]     sq_side_r [SQ_STEPS+1];
  logic              sq_valid_r [SQ_STEPS+1];

  always_comb begin
    sq_rad_r[0]   = s5_sum_r;
    sq_rem_r[0]   = '0;
    sq_root_r[0]  = '0;
    sq_zero_r[0]  = s5_zero_r;
    sq_side_r[0]  = s5_side_r;
    sq_valid_r[0] = s5_valid_r;
    for (int i = 0; i < N; i++) sq_a_r[0][i] = s5_a_r[i];
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [SREM_W-1:0] shifted;
    logic [SREM_W-1:0] trial;
    logic [SREM_W-1:0] rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    always_comb begin
      shifted = {sq_rem_r[k][SREM_W-3:0], sq_rad_r[k][SUM_W-1 -: 2]};
      trial   = SREM_W'({sq_root_r[k], 2'b01});
      if (shifted >= trial) begin
        rem_nxt  = shifted - trial;
        root_nxt = {sq_root_r[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted;
        root_nxt = {sq_root_r[k][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_valid_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_valid_r[k+1] <= sq_valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rad_r[k+1]  <= {sq_rad_r[k][SUM_W-3:0], 2'b00};
        sq_rem_r[k+1]  <= rem_nxt;
        sq_root_r[k+1] <= root_nxt;
        sq_zero_r[k+1] <= sq_zero_r[k];
        sq_side_r[k+1] <= sq_side_r[k];
        for (int i = 0; i < N; i++) sq_a_r[k+1][i] <= sq_a_r[k][i];
      end
    end
  end

  // Restoring division of each component by the length, one quotient bit per stage.
  logic [DEN_W-1:0]  dv_rem_r  [DV_STEPS+1][N];
  logic [UW-1:0]     dv_q_r    [DV_STEPS+1][N];
  logic [ROOT_W-1:0] dv_len_r  [DV_STEPS+1];
  logic              dv_zero_r [DV_STEPS+1];
  logic [SW-1:0]     dv_side_r [DV_STEPS+1];
  logic              dv_valid_r [DV_STEPS+1];

  always_comb begin
    dv_len_r[0]   = sq_root_r[SQ_STEPS];
    dv_zero_r[0]  = sq_zero_r[SQ_STEPS];
    dv_side_r[0]  = sq_side_r[SQ_STEPS];
    dv_valid_r[0] = sq_valid_r[SQ_STEPS];
    for (int i = 0; i < N; i++) begin
      dv_rem_r[0][i] = DEN_W'(sq_a_r[SQ_STEPS][i]) << FRAC;
      dv_q_r[0][i]   = '0;
    end
  end

  for (genvar d = 0; d < DV_STEPS; d++) begin : g_div
    localparam int J = FRAC - d;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem_nxt [N];
    logic [UW-1:0]    q_nxt [N];

    always_comb begin
      den = DEN_W'(dv_len_r[d]) << J;
      for (int i = 0; i < N; i++) begin
        rem_nxt[i] = dv_rem_r[d][i];
        q_nxt[i]   = dv_q_r[d][i];
        if (dv_rem_r[d][i] >= den) begin
          rem_nxt[i]  = dv_rem_r[d][i] - den;
          q_nxt[i][J] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[d+1] <= 1'b0;
      end else if (en) begin
        dv_valid_r[d+1] <= dv_valid_r[d];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_len_r[d+1]  <= dv_len_r[d];
        dv_zero_r[d+1] <= dv_zero_r[d];
        dv_side_r[d+1] <= dv_side_r[d];
        for (int i = 0; i < N; i++) begin
          dv_rem_r[d+1][i] <= rem_nxt[i];
          dv_q_r[d+1][i]   <= q_nxt[i];
        end
      end
    end
  end

  assign out_valid = dv_valid_r[DV_STEPS];
  assign out_zero  = dv_zero_r[DV_STEPS];
  assign out_side  = dv_side_r[DV_STEPS];
  always_comb begin
    for (int i = 0; i < N; i++) out_u[i] = dv_q_r[DV_STEPS][i];
  end

endmodule

[rtl/orbit_toward_point_steering.sv]
// Top level of the orbit-toward-point steering pipeline.
//
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  in      | in_valid/in_ready, in_pos_*, ...   | word in
//  out     | out_valid/out_ready, out_vel_*     | word out
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata    | register write
//
// One word enters per cycle while in_ready is high. Each unit-vector unit holds a
// 31-stage square root followed by a FRAC_BITS+1 stage divider. All stages advance
// together whenever the output register is empty or being taken, so a stall freezes the
// whole pipe without losing a word. Reset is synchronous; it clears the valid bits and
// sets the configuration registers to their defaults.
module orbit_toward_point_steering #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]       in_pos_y,
  input  logic signed [COORD_WIDTH-1:0]       in_pos_z,
  input  logic signed [COORD_WIDTH-1:0]       in_center_x,
  input  logic signed [COORD_WIDTH-1:0]       in_center_y,
  input  logic signed [COORD_WIDTH-1:0]       in_center_z,
  input  logic signed [COORD_WIDTH-1:0]       in_goal_x,
  input  logic signed [COORD_WIDTH-1:0]       in_goal_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ost_pkg::VEL_W-1:0]    out_vel_x,
  output logic signed [ost_pkg::VEL_W-1:0]    out_vel_z,
  output logic                                out_degenerate,
  input  logic                                cfg_wr_en,
  input  logic [ost_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [ost_pkg::REG_W-1:0]           cfg_wdata
);
  import ost_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int UW = FRAC_BITS + 1;
  localparam int SW_A = 2;
  localparam int SW_B = 2;
  localparam int SW_C = 2 * VSUM_W + 2;

  // Config registers; the user must write them only while the pipe is empty (unchecked).
  logic [REG_W-1:0] speed_r;
  logic             cw_r;
  logic [REG_W-1:0] weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r  <= SPEED_RESET;
      cw_r     <= 1'b0;
      weight_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ORBIT_SPEED:    speed_r  <= cfg_wdata;
        REG_TURN_CLOCKWISE: cw_r     <= cfg_wdata[0];
        REG_GOAL_WEIGHT:    weight_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The whole pipe moves when the output register can accept a word.
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Stage r0: input capture.
  logic                          r0_valid_r;
  logic signed [COORD_WIDTH-1:0] r0_px_r, r0_py_r, r0_pz_r;
  logic signed [COORD_WIDTH-1:0] r0_cx_r, r0_cy_r, r0_cz_r, r0_gx_r, r0_gz_r;

  // Stage r1: differences as magnitude and sign.
  logic signed [DW-1:0] dx, dy, dz, gx, gz;
  logic                 r1_valid_r;
  logic [DW-1:0]        r1_mc_r [3];
  logic [DW-1:0]        r1_mg_r [2];
  logic                 r1_dz_pos_r, r1_dx_neg_r, r1_gx_neg_r, r1_gz_neg_r;

  assign dx = DW'(r0_cx_r) - DW'(r0_px_r);
  assign dy = DW'(r0_cy_r) - DW'(r0_py_r);
  assign dz = DW'(r0_cz_r) - DW'(r0_pz_r);
  assign gx = DW'(r0_gx_r) - DW'(r0_px_r);
  assign gz = DW'(r0_gz_r) - DW'(r0_pz_r);

  function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] v);
    mag_of = v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r0_valid_r <= 1'b0;
      r1_valid_r <= 1'b0;
    end else if (en) begin
      r0_valid_r <= in_valid;
      r1_valid_r <= r0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0_px_r <= in_pos_x;
      r0_py_r <= in_pos_y;
      r0_pz_r <= in_pos_z;
      r0_cx_r <= in_center_x;
      r0_cy_r <= in_center_y;
      r0_cz_r <= in_center_z;
      r0_gx_r <= in_goal_x;
      r0_gz_r <= in_goal_z;
      r1_mc_r[0]  <= mag_of(dx);
      r1_mc_r[1]  <= mag_of(dy);
      r1_mc_r[2]  <= mag_of(dz);
      r1_mg_r[0]  <= mag_of(gx);
      r1_mg_r[1]  <= mag_of(gz);
      r1_dz_pos_r <= !dz[DW-1] && (dz != '0);
      r1_dx_neg_r <= dx[DW-1];
      r1_gx_neg_r <= gx[DW-1];
      r1_gz_neg_r <= gz[DW-1];
    end
  end

  // Unit direction toward the centre (3D) and toward the goal (xz plane).
  logic          ua_valid, ua_zero;
  logic [UW-1:0] ua_u [3];
  logic [SW_A-1:0] ua_side;
  logic          ub_valid, ub_zero;
  logic [UW-1:0] ub_u [2];
  logic [SW_B-1:0] ub_side;

  ost_unit #(.N(3), .MW(DW), .FRAC(FRAC_BITS), .SW(SW_A)) u_center (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(r1_valid_r), .in_mag(r1_mc_r), .in_side({r1_dz_pos_r, r1_dx_neg_r}),
    .out_valid(ua_valid), .out_u(ua_u), .out_zero(ua_zero), .out_side(ua_side)
  );

  ost_unit #(.N(2), .MW(DW), .FRAC(FRAC_BITS), .SW(SW_B)) u_goal (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(r1_valid_r), .in_mag(r1_mg_r), .in_side({r1_gx_neg_r, r1_gz_neg_r}),
    .out_valid(ub_valid), .out_u(ub_u), .out_zero(ub_zero), .out_side(ub_side)
  );

  // Stage r2: tangent and goal terms, truncated toward zero, sign kept aside.
  logic [UW+REG_W-1:0] p_tx, p_tz, p_gx, p_gz;
  assign p_tx = UW'(ua_u[2]) * speed_r;
  assign p_tz = UW'(ua_u[0]) * speed_r;
  assign p_gx = UW'(ub_u[0]) * weight_r;
  assign p_gz = UW'(ub_u[1]) * weight_r;

  logic             r2_valid_r, r2_degen_r;
  logic [VEL_W-1:0] r2_tx_r, r2_tz_r, r2_gx_r, r2_gz_r;
  logic             r2_ntx_r, r2_ntz_r, r2_ngx_r, r2_ngz_r;

  // Stage r3: signed sums.
  logic signed [VSUM_W-1:0] r3_vx_r, r3_vz_r;
  logic                     r3_valid_r, r3_degen_r;

  function automatic logic signed [VSUM_W-1:0] apply_sign(input logic [VEL_W-1:0] m,
                                                          input logic neg);
    apply_sign = neg ? -$signed(VSUM_W'(m)) : $signed(VSUM_W'(m));
  endfunction

  // Stage r4: magnitudes squared. Stage r5: clamp decision.
  logic [VMAG_W-1:0] ax, az;
  assign ax = r3_vx_r[VSUM_W-1] ? VMAG_W'(-r3_vx_r) : VMAG_W'(r3_vx_r);
  assign az = r3_vz_r[VSUM_W-1] ? VMAG_W'(-r3_vz_r) : VMAG_W'(r3_vz_r);

  logic                     r4_valid_r, r4_degen_r;
  logic signed [VSUM_W-1:0] r4_vx_r, r4_vz_r;
  logic [VMAG_W-1:0]        r4_ax_r, r4_az_r;
  logic [2*VMAG_W-1:0]      r4_ax2_r, r4_az2_r;
  logic [2*REG_W-1:0]       r4_sp2_r;

  logic                     r5_valid_r, r5_degen_r, r5_clamp_r;
  logic signed [VSUM_W-1:0] r5_vx_r, r5_vz_r;
  logic [VMAG_W-1:0]        r5_mv_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r2_valid_r <= 1'b0;
      r3_valid_r <= 1'b0;
      r4_valid_r <= 1'b0;
      r5_valid_r <= 1'b0;
    end else if (en) begin
      r2_valid_r <= ua_valid && ub_valid;
      r3_valid_r <= r2_valid_r;
      r4_valid_r <= r3_valid_r;
      r5_valid_r <= r4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_degen_r <= ua_zero || ub_zero;
      r2_tx_r    <= p_tx[FRAC_BITS +: VEL_W];
      r2_tz_r    <= p_tz[FRAC_BITS +: VEL_W];
      r2_gx_r    <= p_gx[FRAC_BITS +: VEL_W];
      r2_gz_r    <= p_gz[FRAC_BITS +: VEL_W];
      r2_ntx_r   <= ua_side[1] ^ cw_r;
      r2_ntz_r   <= ua_side[0] ^ cw_r;
      r2_ngx_r   <= ub_side[1];
      r2_ngz_r   <= ub_side[0];

      r3_degen_r <= r2_degen_r;
      r3_vx_r    <= apply_sign(r2_tx_r, r2_ntx_r) + apply_sign(r2_gx_r, r2_ngx_r);
      r3_vz_r    <= apply_sign(r2_tz_r, r2_ntz_r) + apply_sign(r2_gz_r, r2_ngz_r);

      r4_degen_r <= r3_degen_r;
      r4_vx_r    <= r3_vx_r;
      r4_vz_r    <= r3_vz_r;
      r4_ax_r    <= ax;
      r4_az_r    <= az;
      r4_ax2_r   <= ax * ax;
      r4_az2_r   <= az * az;
      r4_sp2_r   <= speed_r * speed_r;

      r5_degen_r <= r4_degen_r;
      r5_vx_r    <= r4_vx_r;
      r5_vz_r    <= r4_vz_r;
      r5_mv_r[0] <= r4_ax_r;
      r5_mv_r[1] <= r4_az_r;
      // The sum is kept one bit wider, so the comparison is exact.
      r5_clamp_r <= ((2*VMAG_W+1)'(r4_ax2_r) + (2*VMAG_W+1)'(r4_az2_r))
                    > (2*VMAG_W+1)'(r4_sp2_r);
    end
  end

  // Unit direction of the velocity, used only when it is too long.
  logic            uc_valid, uc_zero;
  logic [UW-1:0]   uc_u [2];
  logic [SW_C-1:0] uc_side;

  ost_unit #(.N(2), .MW(VMAG_W), .FRAC(FRAC_BITS), .SW(SW_C)) u_clamp (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(r5_valid_r), .in_mag(r5_mv_r),
    .in_side({r5_degen_r, r5_clamp_r, r5_vx_r, r5_vz_r}),
    .out_valid(uc_valid), .out_u(uc_u), .out_zero(uc_zero), .out_side(uc_side)
  );

  // Output stage: rebuild clamped velocity at orbit speed or pass sum; zero if degenerate.
  logic                     c_degen, c_clamp;
  logic signed [VSUM_W-1:0] c_vx, c_vz;
  logic [UW+REG_W-1:0]      p_cx, p_cz;
  logic [VEL_W-1:0]         m_cx, m_cz;
  logic signed [VEL_W-1:0]  vx_nxt, vz_nxt;

  assign {c_degen, c_clamp, c_vx, c_vz} = uc_side;
  assign p_cx = UW'(uc_u[0]) * speed_r;
  assign p_cz = UW'(uc_u[1]) * speed_r;
  assign m_cx = p_cx[FRAC_BITS +: VEL_W];
  assign m_cz = p_cz[FRAC_BITS +: VEL_W];

  always_comb begin
    if (c_degen) begin
      vx_nxt = '0;
      vz_nxt = '0;
    end else if (c_clamp) begin
      if (uc_zero) begin
        vx_nxt = '0;
        vz_nxt = '0;
      end else begin
        vx_nxt = c_vx[VSUM_W-1] ? -$signed(m_cx) : $signed(m_cx);
        vz_nxt = c_vz[VSUM_W-1] ? -$signed(m_cz) : $signed(m_cz);
      end
    end else begin
      vx_nxt = c_vx[VEL_W-1:0];
      vz_nxt = c_vz[VEL_W-1:0];
    end
  end

  logic signed [VEL_W-1:0] vel_x_r, vel_z_r;
  logic                    degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= uc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vel_x_r <= vx_nxt;
      vel_z_r <= vz_nxt;
      degen_r <= c_degen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_vel_x      = vel_x_r;
  assign out_vel_z      = vel_z_r;
  assign out_degenerate = degen_r;

endmodule

[tb/sv/tb_orbit_toward_point_steering.sv]
// Self-checking testbench for the orbit-toward-point steering pipeline.
`timescale 1ns / 100ps

module tb_orbit_toward_point_steering;
  import ost_pkg::*;

  // The 2-bit index has one code beyond the last register; a write to it must be ignored.
  localparam logic [CIDX_W-1:0] REG_NONE = 2'd3;
  localparam int FB = 16;
  localparam int LATENCY = 2 * FB + 81;
  localparam int CYCLE_LIMIT = 600000;
  localparam int N_RANDOM = 1950;

  typedef struct {
    logic signed [31:0] px, py, pz, cx, cy, cz, gx, gz;
  } mover_t;

  typedef struct {
    logic signed [31:0] vx, vz;
    logic               degen;
  } velocity_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [31:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic signed [31:0] in_goal_x = '0, in_goal_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [VEL_W-1:0] out_vel_x, out_vel_z;
  logic out_degenerate;
  logic cfg_wr_en = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_wdata = '0;

  orbit_toward_point_steering dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Our copy of the register file, updated as each write lands.
  longint unsigned speed_q = 64'd65536;
  logic            clockwise_q = 1'b0;
  longint unsigned weight_q = 64'd0;

  mover_t    pending_movers[$];
  velocity_t expected_vel[$];
  int        words_queued = 0;
  int        words_checked = 0;
  int        mismatches = 0;
  int        degenerate_seen = 0;
  longint    cycles = 0;

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Direction magnitudes of up to three components, after a shared normalizing shift
  // that puts the largest component's top bit at NORM_TOP. Returns 0 for a null vector.
  function automatic bit unit_dir(input longint unsigned m[3], input int n,
                                  output longint unsigned u[3]);
    longint unsigned mx = 0, sum = 0, len;
    longint unsigned a[3];
    int p = 0;
    u = '{0, 0, 0};
    for (int i = 0; i < n; i++) if (m[i] > mx) mx = m[i];
    if (mx == 0) return 1'b0;
    while ((mx >> p) > 1) p++;
    for (int i = 0; i < n; i++) begin
      a[i] = (p > NORM_TOP) ? m[i] >> (p - NORM_TOP) : m[i] << (NORM_TOP - p);
      sum += a[i] * a[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < n; i++) u[i] = (a[i] << FB) / len;
    return 1'b1;
  endfunction

  // Product with a Q16.16 gain, truncated toward zero.
  function automatic longint scaled(longint unsigned u, longint unsigned k, bit neg);
    longint unsigned r = (u * k) >> FB;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic velocity_t steer_velocity(mover_t w);
    velocity_t r;
    longint dx, dy, dz, gx, gz, vx, vz;
    longint unsigned mc[3], uc[3], mg[3], ug[3], mv[3], uv[3];
    longint unsigned ax, az, sx, s;
    dx = longint'(w.cx) - longint'(w.px);
    dy = longint'(w.cy) - longint'(w.py);
    dz = longint'(w.cz) - longint'(w.pz);
    gx = longint'(w.gx) - longint'(w.px);
    gz = longint'(w.gz) - longint'(w.pz);
    mc = '{abs64(dx), abs64(dy), abs64(dz)};
    mg = '{abs64(gx), abs64(gz), 0};
    r.degen = 1'b0;
    if (!unit_dir(mc, 3, uc) || !unit_dir(mg, 2, ug)) begin
      r.vx = '0;
      r.vz = '0;
      r.degen = 1'b1;
      return r;
    end
    // Tangent (-uz, ux) scaled by speed and the turn sign, plus the pull to the goal.
    vx = scaled(uc[2], speed_q, (dz > 0) != clockwise_q) + scaled(ug[0], weight_q, gx < 0);
    vz = scaled(uc[0], speed_q, (dx < 0) != clockwise_q) + scaled(ug[1], weight_q, gz < 0);
    ax = abs64(vx);
    az = abs64(vz);
    sx = ax * ax;
    s = sx + az * az;
    if (s < sx || s > speed_q * speed_q) begin
      mv = '{ax, az, 0};
      if (unit_dir(mv, 2, uv)) begin
        vx = scaled(uv[0], speed_q, vx < 0);
        vz = scaled(uv[1], speed_q, vz < 0);
      end else begin
        vx = 0;
        vz = 0;
      end
    end
    r.vx = vx[31:0];
    r.vz = vz[31:0];
    return r;
  endfunction

  // Driver: bursts of words separated by random gaps. A word is predicted when accepted.
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk) begin
    mover_t w;
    bit taken;
    taken = in_valid && in_ready;
    if (taken) begin
      w = '{in_pos_x, in_pos_y, in_pos_z, in_center_x, in_center_y, in_center_z,
            in_goal_x, in_goal_z};
      expected_vel.push_back(steer_velocity(w));
    end
    if (rst_n && (!in_valid || taken)) begin
      if (gap_left > 0 || pending_movers.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        w = pending_movers.pop_front();
        in_pos_x <= w.px;
        in_pos_y <= w.py;
        in_pos_z <= w.pz;
        in_center_x <= w.cx;
        in_center_y <= w.cy;
        in_center_z <= w.cz;
        in_goal_x <= w.gx;
        in_goal_z <= w.gz;
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver: switches between always ready, random stalls and long stalls.
  int stall_mode = 0;
  int mode_left = 50;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Monitor: compare each result word with the oldest prediction.
  always @(posedge clk) begin
    velocity_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_vel.size() == 0) begin
        $display("%0t: unexpected result word vel_x=%0d vel_z=%0d degenerate=%0b",
                 $time, out_vel_x, out_vel_z, out_degenerate);
        mismatches++;
      end else begin
        e = expected_vel.pop_front();
        if (out_vel_x !== e.vx) begin
          $display("%0t: vel_x expected %0d actual %0d", $time, e.vx, out_vel_x);
          mismatches++;
        end
        if (out_vel_z !== e.vz) begin
          $display("%0t: vel_z expected %0d actual %0d", $time, e.vz, out_vel_z);
          mismatches++;
        end
        if (out_degenerate !== e.degen) begin
          $display("%0t: degenerate expected %0b actual %0b", $time, e.degen,
                   out_degenerate);
          mismatches++;
        end
        if (e.degen) degenerate_seen++;
      end
      words_checked++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d words checked", cycles,
               words_checked, words_queued);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_ORBIT_SPEED:    speed_q = 64'(val);
      REG_TURN_CLOCKWISE: clockwise_q = val[0];
      REG_GOAL_WEIGHT:    weight_q = 64'(val);
      default: ;
    endcase
  endtask

  task automatic queue_mover(mover_t w);
    pending_movers.push_back(w);
    words_queued++;
  endtask

  // Wait until every queued word has come back, so registers can change safely.
  task automatic drain();
    while (words_checked != words_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] any_coord();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  // Offset from the mover: none, small, medium, or anything at all (wrapping is legal).
  function automatic logic signed [31:0] offset_from(logic signed [31:0] base);
    case ($urandom_range(0, 5))
      0: return base + ($signed($urandom_range(0, 6)) - 3);
      1: return base + ($signed($urandom_range(0, 32'h1fffff)) - 32'sh100000);
      2: return base;
      default: return $urandom;
    endcase
  endfunction

  function automatic mover_t random_mover();
    mover_t w;
    w.px = any_coord();
    w.py = any_coord();
    w.pz = any_coord();
    w.cx = offset_from(w.px);
    w.cy = offset_from(w.py);
    w.cz = offset_from(w.pz);
    w.gx = offset_from(w.px);
    w.gz = offset_from(w.pz);
    // Sometimes park the mover exactly on the centre or on the goal.
    case ($urandom_range(0, 29))
      0: begin
        w.cx = w.px;
        w.cy = w.py;
        w.cz = w.pz;
      end
      1: begin
        w.gx = w.px;
        w.gz = w.pz;
      end
      default: ;
    endcase
    return w;
  endfunction

  localparam logic signed [31:0] MAXC = 32'sh7fffffff;
  localparam logic signed [31:0] MINC = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh10000;

  initial begin
    logic [REG_W-1:0] speeds[6];
    logic [REG_W-1:0] weights[6];
    int per_phase;
    speeds = '{31'd0, 31'h7fffffff, 31'd196608, 31'd1, 31'd65536, 31'd1000000};
    weights = '{31'd65536, 31'h7fffffff, 31'd32768, 31'd0, 31'd200000, 31'd3};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under reset settings: speed 1.0, counterclockwise, no goal pull.
    queue_mover('{0, 0, 0, ONE, 0, 0, 0, ONE});
    queue_mover('{0, 0, 0, 0, 0, ONE, ONE, 0});
    queue_mover('{0, 0, 0, -ONE, ONE, -ONE, -ONE, -ONE});
    queue_mover('{ONE, ONE, ONE, ONE, ONE, ONE, 0, 0});           // mover on the centre
    queue_mover('{ONE, 5, -ONE, 0, 0, 0, ONE, -ONE});             // mover on the goal
    queue_mover('{MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MINC});
    queue_mover('{MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MAXC});
    queue_mover('{MAXC, 0, MINC, MAXC, 0, MINC + 1, MINC, MAXC});
    queue_mover('{0, 0, 0, 1, 0, 0, 0, 1});
    queue_mover('{0, 0, 0, 0, 1, 0, 1, 0});                       // centre straight above
    queue_mover('{-1, -1, -1, 0, 0, 0, 0, 0});
    queue_mover('{0, MAXC, 0, 0, MINC, 0, 7, 0});
    drain();

    // Strong goal pull with clockwise turn; forces the clamp on the words not degenerate.
    write_reg(REG_GOAL_WEIGHT, 31'h7fffffff);
    write_reg(REG_TURN_CLOCKWISE, 31'd1);
    write_reg(REG_NONE, 31'h7fffffff);
    queue_mover('{0, 0, 0, ONE, 0, 0, -ONE, ONE});
    queue_mover('{MINC, 0, MAXC, MAXC, 0, MINC, MAXC, MAXC});
    queue_mover('{ONE, ONE, ONE, ONE, ONE, ONE, 0, 0});
    queue_mover('{3, 0, 3, 3, 0, 3, 0, 0});
    drain();

    // Random phases, each under a new register setting, extremes among them.
    per_phase = N_RANDOM / 6;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_ORBIT_SPEED, speeds[ph]);
      write_reg(REG_TURN_CLOCKWISE, REG_W'(ph[0]));
      write_reg(REG_GOAL_WEIGHT, weights[ph]);
      for (int i = 0; i < per_phase; i++) queue_mover(random_mover());
      drain();
    end

    repeat (LATENCY + 20) @(posedge clk);
    $display("checked %0d words over 8 register settings, %0d of them degenerate",
             words_checked, degenerate_seen);
    $display("stalls and bursts on both channels, %0d cycles in all", cycles);
    if (mismatches == 0 && expected_vel.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d predictions left over", mismatches,
               expected_vel.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ost_pkg.sv
rtl/ost_unit.sv
rtl/orbit_toward_point_steering.sv
tb/sv/tb_orbit_toward_point_steering.sv
